FILE: design/midi_note_echo_generator_macros.svh
// ----------------------------------------------------------------------------
// midi note echo generator assertion macros
// shared assertion shorthands, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_ECHO_GENERATOR_MACROS_SVH
`define MIDI_NOTE_ECHO_GENERATOR_MACROS_SVH

// a property that must hold at every edge out of reset
`define MNEG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mneg assertion failed");

// a condition that implies something at the next edge
`define MNEG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mneg assertion failed");

`endif

FILE: design/mneg_pkg.sv
// ----------------------------------------------------------------------------
// mneg_pkg
// types and constants shared by the midi note echo generator modules
// ----------------------------------------------------------------------------
package mneg_pkg;

  // repeat limits
  localparam int unsigned MAX_REPEATS_DEF = 16;
  localparam int unsigned MAX_REPEATS_HI  = 64;
  localparam int unsigned REPS_W          = $clog2(MAX_REPEATS_HI + 1);

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RC_W      = 5;
  localparam int unsigned TPQ_W     = 16;
  localparam int unsigned SPACING_SHIFT = 3;
  localparam int unsigned SPACING_W = TPQ_W - SPACING_SHIFT;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_QUARTER = 1'd1;
  localparam logic [RC_W-1:0]  RST_REPEAT_COUNT      = 5'd4;
  localparam logic [TPQ_W-1:0] RST_TICKS_PER_QUARTER = 16'd480;

  // message kinds
  localparam logic [BYTE_W-1:0] KIND_MASK     = 8'hF0;
  localparam logic [BYTE_W-1:0] KIND_NOTE_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] KIND_NOTE_OFF = 8'h80;
  localparam logic [BYTE_W-1:0] VEL_FLOOR     = 8'd10;

  // velocity ramp divider
  localparam int unsigned DIV_STEPS = BYTE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0]        status_byte;
    logic [BYTE_W-1:0]        first_data;
    logic [BYTE_W-1:0]        second_data;
    logic signed [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]        out_status;
    logic [BYTE_W-1:0]        out_first_data;
    logic [BYTE_W-1:0]        out_second_data;
    logic signed [TIME_W-1:0] out_time;
    logic                     run_last;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t             item;
    logic [REPS_W-1:0]    reps;
    logic [SPACING_W-1:0] spacing;
    logic                 ramp;
    logic                 span_neg;
    logic [BYTE_W-1:0]    span_mag;
  } entry_t;

endpackage

FILE: design/mneg_queue.sv
// ----------------------------------------------------------------------------
// mneg_queue
// short register queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
module mneg_queue #(
  parameter int unsigned DEPTH = mneg_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  mneg_pkg::entry_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output mneg_pkg::entry_t rd_data_o,
  output logic             valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mneg_pkg::entry_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (rd_i && !wr_i) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: design/mneg_front.sv
// ----------------------------------------------------------------------------
// mneg_front
// configuration registers and classification of incoming midi items
// ----------------------------------------------------------------------------
module mneg_front #(
  parameter int unsigned MAX_REPEATS = mneg_pkg::MAX_REPEATS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mneg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mneg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  mneg_pkg::in_item_t                  item_i,
  output mneg_pkg::entry_t                    entry_o
);

  localparam int unsigned RW = mneg_pkg::REPS_W;

  logic [mneg_pkg::RC_W-1:0]  repeat_count_q;
  logic [mneg_pkg::TPQ_W-1:0] ticks_per_quarter_q;
  logic [RW-1:0]              rc_w;
  logic [RW-1:0]              reps;
  logic [mneg_pkg::BYTE_W-1:0] kind;
  logic                       is_on;
  logic                       is_note;
  logic                       span_neg;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q      <= mneg_pkg::RST_REPEAT_COUNT;
      ticks_per_quarter_q <= mneg_pkg::RST_TICKS_PER_QUARTER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mneg_pkg::CFG_REPEAT_COUNT: begin
          repeat_count_q <= cfg_data_i[mneg_pkg::RC_W-1:0];
        end
        mneg_pkg::CFG_TICKS_PER_QUARTER: begin
          ticks_per_quarter_q <= cfg_data_i[mneg_pkg::TPQ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // message kind
  assign kind    = item_i.status_byte & mneg_pkg::KIND_MASK;
  assign is_on   = (kind == mneg_pkg::KIND_NOTE_ON);
  assign is_note = is_on || (kind == mneg_pkg::KIND_NOTE_OFF);

  // run length: one for non-notes, zero counts as one, large values saturate
  assign rc_w = RW'(repeat_count_q);
  always_comb begin
    if (!is_note || (rc_w == '0)) begin
      reps = RW'(1);
    end else if (rc_w > RW'(MAX_REPEATS)) begin
      reps = RW'(MAX_REPEATS);
    end else begin
      reps = rc_w;
    end
  end

  // velocity span toward the floor, as sign and magnitude
  assign span_neg = (item_i.second_data > mneg_pkg::VEL_FLOOR);

  assign entry_o.item     = item_i;
  assign entry_o.reps     = reps;
  assign entry_o.spacing  = ticks_per_quarter_q[mneg_pkg::TPQ_W-1:mneg_pkg::SPACING_SHIFT];
  assign entry_o.ramp     = is_on && (item_i.second_data != '0) && (reps != RW'(1));
  assign entry_o.span_neg = span_neg;
  assign entry_o.span_mag = span_neg ? (item_i.second_data - mneg_pkg::VEL_FLOOR)
                                     : (mneg_pkg::VEL_FLOOR - item_i.second_data);

endmodule

FILE: design/mneg_back.sv
// ----------------------------------------------------------------------------
// mneg_back
// emits the run of copies for one item, with the velocity ramp divider
// ----------------------------------------------------------------------------
module mneg_back #(
  parameter int unsigned MAX_REPEATS = mneg_pkg::MAX_REPEATS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  mneg_pkg::entry_t     q_entry_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output mneg_pkg::out_item_t  out_item_o
);

  localparam int unsigned RW  = $clog2(MAX_REPEATS + 1);
  localparam int unsigned BW  = mneg_pkg::BYTE_W;
  localparam int unsigned CW  = mneg_pkg::DIV_CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e  state_q, state_d;
  state_e  after_load;
  logic    ov_q, ov_d;
  logic [RW-1:0] n_q, n_d;
  logic [CW-1:0] bit_cnt_q, bit_cnt_d;

  // item being emitted
  logic [BW-1:0]                    status_q, first_q, vel_q;
  logic [mneg_pkg::TIME_W-1:0]      time_q;
  logic [mneg_pkg::SPACING_W-1:0]   spacing_q;
  logic [RW-1:0]                    reps_q;
  logic                             ramp_q, neg_q;
  // divider: quotient and remainder of span over run length minus one
  logic [BW-1:0] div_q;
  logic [RW-1:0] rem_q;
  // accumulated quotient and remainder of span times copy index
  logic [BW-1:0] qa_q;
  logic [RW-1:0] ra_q;
  mneg_pkg::out_item_t out_q;

  logic          pop_acc, emit, last, load;
  logic [RW-1:0] den;
  logic [RW:0]   den_x, sh, rsum;
  logic          ge, wrap;
  logic [RW-1:0] rem_n, ra_n;
  logic [BW-1:0] vel;

  assign pop_acc = pop_i && ov_q;
  assign last    = (RW'(n_q + 1'b1) == reps_q);
  assign emit    = (state_q == ST_EMIT) && (!ov_q || pop_acc);
  assign load    = q_valid_i && ((state_q == ST_IDLE) || (emit && last));
  assign q_pop_o = load;
  assign after_load = q_entry_i.ramp ? ST_DIV : ST_EMIT;

  // restoring divide step
  assign den   = RW'(reps_q - 1'b1);
  assign den_x = {1'b0, den};
  assign sh    = {rem_q, div_q[BW-1]};
  assign ge    = (sh >= den_x);
  assign rem_n = ge ? RW'(sh - den_x) : sh[RW-1:0];

  // running quotient for the next copy
  assign rsum  = {1'b0, ra_q} + {1'b0, rem_q};
  assign wrap  = (rsum >= den_x);
  assign ra_n  = wrap ? RW'(rsum - den_x) : rsum[RW-1:0];

  // velocity of the current copy, truncated toward zero
  always_comb begin
    if (!ramp_q) begin
      vel = vel_q;
    end else if (neg_q) begin
      vel = vel_q - qa_q;
    end else begin
      vel = vel_q + qa_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    bit_cnt_d = bit_cnt_q;
    ov_d      = emit ? 1'b1 : (pop_acc ? 1'b0 : ov_q);
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = after_load;
        end
      end
      ST_DIV: begin
        bit_cnt_d = CW'(bit_cnt_q + 1'b1);
        if (bit_cnt_q == CW'(mneg_pkg::DIV_STEPS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          n_d = RW'(n_q + 1'b1);
          if (last) begin
            state_d = load ? after_load : ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load) begin
      n_d       = '0;
      bit_cnt_d = '0;
    end
  end

  // state, output valid and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ov_q      <= 1'b0;
      n_q       <= '0;
      bit_cnt_q <= '0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      ov_q      <= ov_d;
      n_q       <= n_d;
      bit_cnt_q <= bit_cnt_d;
      if (emit) begin
        out_q.out_status      <= status_q;
        out_q.out_first_data  <= first_q;
        out_q.out_second_data <= vel;
        out_q.out_time        <= $signed(time_q);
        out_q.run_last        <= last;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= q_entry_i.item.status_byte;
      first_q   <= q_entry_i.item.first_data;
      vel_q     <= q_entry_i.item.second_data;
      time_q    <= q_entry_i.item.event_time;
      spacing_q <= q_entry_i.spacing;
      reps_q    <= RW'(q_entry_i.reps);
      ramp_q    <= q_entry_i.ramp;
      neg_q     <= q_entry_i.span_neg;
      div_q     <= q_entry_i.span_mag;
      rem_q     <= '0;
      qa_q      <= '0;
      ra_q      <= '0;
    end else if (state_q == ST_DIV) begin
      div_q <= {div_q[BW-2:0], ge};
      rem_q <= rem_n;
    end else if (emit) begin
      time_q <= time_q + mneg_pkg::TIME_W'(spacing_q);
      qa_q   <= BW'(qa_q + div_q + BW'(wrap));
      ra_q   <= ra_n;
    end
  end

  assign empty_o    = !ov_q;
  assign out_item_o = out_q;

endmodule

FILE: design/midi_note_echo_generator.sv
// ----------------------------------------------------------------------------
// midi_note_echo_generator
// echoes midi note-on and note-off items as runs of delayed copies
// ----------------------------------------------------------------------------
// Input items enter through push/full; an item is taken when push is high
// and full is low. Results leave through empty/pop; the oldest result sits
// on out_item_o while empty is low and is taken when pop is high.
// A note item gives repeat_count copies (zero counts as one, saturated at
// MAX_REPEATS), each a thirty-second note later than the one before; a
// note-on with velocity ramps its velocity toward 10. Other items pass once.
// The first result of an item appears in the output register after the item
// has passed the queue and the emitting side; for a ramped note-on the
// velocity divider first takes one bit per cycle. After that one result
// leaves each cycle while pop keeps taking results; a note item holds the
// emitting side for its run of copies. A four-entry queue lets items keep
// arriving while a run is emitted. When pop stays low the output register
// holds its result and the queue fills, then full rises. Reset empties the
// queue and the output and loads repeat_count 4, ticks_per_quarter 480.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i.
// ----------------------------------------------------------------------------
module midi_note_echo_generator #(
  parameter int unsigned MAX_REPEATS = mneg_pkg::MAX_REPEATS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mneg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mneg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  mneg_pkg::in_item_t              in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output mneg_pkg::out_item_t             out_item_o
);

  mneg_pkg::entry_t fe_entry;
  mneg_pkg::entry_t q_entry;
  logic             q_full, q_valid, q_pop, q_push;

  assign q_push = push && !q_full;
  assign full   = q_full;

  // classification front
  mneg_front #(
    .MAX_REPEATS(MAX_REPEATS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .item_i    (in_item_i),
    .entry_o   (fe_entry)
  );

  // decoupling queue
  mneg_queue #(
    .DEPTH(mneg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_push),
    .wr_data_i(fe_entry),
    .full_o   (q_full),
    .rd_i     (q_pop),
    .rd_data_o(q_entry),
    .valid_o  (q_valid)
  );

  // emitting back
  mneg_back #(
    .MAX_REPEATS(MAX_REPEATS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_item_o(out_item_o)
  );

endmodule

FILE: design/mneg_checker.sv
// ----------------------------------------------------------------------------
// mneg_checker
// port-level checks on the midi note echo generator, bound to the top level
// ----------------------------------------------------------------------------
`include "midi_note_echo_generator_macros.svh"

module mneg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            empty,
  input logic                            pop,
  input mneg_pkg::out_item_t             out_item_o
);

  logic [mneg_pkg::BYTE_W-1:0] out_kind;
  logic                        out_is_note;

  assign out_kind    = out_item_o.out_status & mneg_pkg::KIND_MASK;
  assign out_is_note = (out_kind == mneg_pkg::KIND_NOTE_ON) ||
                       (out_kind == mneg_pkg::KIND_NOTE_OFF);

  // a waiting result stays put until taken
  `MNEG_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item_o))

  // anything but a note message yields a single result
  `MNEG_ASSERT(a_pass_single, empty || out_is_note || out_item_o.run_last)

  // copies of one run follow each other with the same status and note
  `MNEG_ASSERT_NEXT(a_run_same_note, pop && !empty && !out_item_o.run_last,
    empty || (out_item_o.out_status == $past(out_item_o.out_status) &&
              out_item_o.out_first_data == $past(out_item_o.out_first_data)))

endmodule

bind midi_note_echo_generator mneg_checker u_mneg_checker (.*);
